// ===== sv/gb2d_pkg.sv =====
package gb2d_pkg;

  localparam int PIX_W   = 8;
  localparam int WGT_W   = 16;
  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_WEIGHT_R2_0  = 3'd2,
    REG_WEIGHT_R2_1  = 3'd3,
    REG_WEIGHT_R2_2  = 3'd4,
    REG_WEIGHT_R2_4  = 3'd5,
    REG_WEIGHT_R2_5  = 3'd6,
    REG_WEIGHT_R2_8  = 3'd7
  } cfg_reg_e;

  localparam int CLS_R2_0  = 0;
  localparam int CLS_R2_1  = 1;
  localparam int CLS_R2_2  = 2;
  localparam int CLS_R2_4  = 3;
  localparam int CLS_R2_5  = 4;
  localparam int CLS_R2_8  = 5;
  localparam int W_CLASSES = 6;

  typedef logic [W_CLASSES-1:0][WGT_W-1:0] weight_set_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               frame_done;
  } item_meta_t;

  // Squared distance 3, 6 and 7 cannot occur for a radius of at most two.
  function automatic int tap_class(int dy, int dx);
    int d2;
    d2 = dx * dx + dy * dy;
    case (d2)
      0:       return CLS_R2_0;
      1:       return CLS_R2_1;
      2:       return CLS_R2_2;
      4:       return CLS_R2_4;
      5:       return CLS_R2_5;
      8:       return CLS_R2_8;
      default: return CLS_R2_0;
    endcase
  endfunction

endpackage

// ===== sv/gaussian_blur_2d.sv =====
// Streaming 2-D Gaussian blur of 8-bit pixels over a (2*RADIUS+1)-square window.
// Pixels enter in raster order, one item per clock when the output side keeps
// up; each accepted pixel is written to a line-store memory of 2*RADIUS rows
// (one word per column, one byte per row) that is read on acceptance and written
// back as the pixel leaves the line-store register, then shifts one column into
// the window, and interior pixels pass a three-stage multiply, row-sum and total
// pipeline. Border pixels give no result. Frame size and the six Q0.16 tap
// weights (one per squared distance) are to be written through the configuration
// port by the user only while the block is idle; the block does not enforce it.
module gaussian_blur_2d #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int RADIUS      = 2,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gb2d_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [gb2d_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gb2d_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gb2d_pkg::PIX_W-1:0]    blurred_o,
  output logic [gb2d_pkg::COORD_W-1:0]  out_x_o,
  output logic [gb2d_pkg::COORD_W-1:0]  out_y_o,
  output logic                          frame_done_o
);

  localparam int LINES  = 2 * RADIUS;
  localparam int DIAM   = 2 * RADIUS + 1;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int SLOT_W = $clog2(LINES);

  logic [gb2d_pkg::DIM_W-1:0] width_q;
  logic [gb2d_pkg::DIM_W-1:0] height_q;
  gb2d_pkg::weight_set_t      weights_q;
  logic [CW-1:0]              col_cnt_q;
  logic [CW-1:0]              col_cnt_d;
  logic [RW-1:0]              row_cnt_q;
  logic [RW-1:0]              row_cnt_d;

  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic [CW-1:0]        x_cur;
  logic [RW-1:0]        y_cur;
  logic [WW-1:0]        x_inc;
  logic [HW-1:0]        y_inc;
  logic                 emit;
  gb2d_pkg::item_meta_t meta_s0;
  logic                 in_accept;
  logic                 cfg_accept;

  logic                                           ls_valid;
  logic                                           ls_emit;
  logic [DIAM-1:0][gb2d_pkg::PIX_W-1:0]           ls_column;
  gb2d_pkg::item_meta_t                           ls_meta;
  logic                                           win_in_ready;
  logic                                           win_valid;
  logic [DIAM-1:0][DIAM-1:0][gb2d_pkg::PIX_W-1:0] win_data;
  gb2d_pkg::item_meta_t                           win_meta;
  logic                                           mac_in_ready;
  gb2d_pkg::item_meta_t                           out_meta;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q                       <= gb2d_pkg::DIM_W'(640);
      height_q                      <= gb2d_pkg::DIM_W'(480);
      weights_q[gb2d_pkg::CLS_R2_0] <= gb2d_pkg::WGT_W'(10624);
      weights_q[gb2d_pkg::CLS_R2_1] <= gb2d_pkg::WGT_W'(6443);
      weights_q[gb2d_pkg::CLS_R2_2] <= gb2d_pkg::WGT_W'(3908);
      weights_q[gb2d_pkg::CLS_R2_4] <= gb2d_pkg::WGT_W'(1437);
      weights_q[gb2d_pkg::CLS_R2_5] <= gb2d_pkg::WGT_W'(872);
      weights_q[gb2d_pkg::CLS_R2_8] <= gb2d_pkg::WGT_W'(194);
    end else if (cfg_accept) begin
      unique case (gb2d_pkg::cfg_reg_e'(cfg_index_i))
        gb2d_pkg::REG_IMAGE_WIDTH:  width_q <= cfg_data_i[gb2d_pkg::DIM_W-1:0];
        gb2d_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i[gb2d_pkg::DIM_W-1:0];
        gb2d_pkg::REG_WEIGHT_R2_0:  weights_q[gb2d_pkg::CLS_R2_0] <= cfg_data_i;
        gb2d_pkg::REG_WEIGHT_R2_1:  weights_q[gb2d_pkg::CLS_R2_1] <= cfg_data_i;
        gb2d_pkg::REG_WEIGHT_R2_2:  weights_q[gb2d_pkg::CLS_R2_2] <= cfg_data_i;
        gb2d_pkg::REG_WEIGHT_R2_4:  weights_q[gb2d_pkg::CLS_R2_4] <= cfg_data_i;
        gb2d_pkg::REG_WEIGHT_R2_5:  weights_q[gb2d_pkg::CLS_R2_5] <= cfg_data_i;
        gb2d_pkg::REG_WEIGHT_R2_8:  weights_q[gb2d_pkg::CLS_R2_8] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  always_comb begin
    x_cur = (frame_start_i || WW'(col_cnt_q) >= w_eff) ? '0 : col_cnt_q;
    y_cur = (frame_start_i || HW'(row_cnt_q) >= h_eff) ? '0 : row_cnt_q;
    x_inc = WW'(x_cur) + WW'(1);
    y_inc = HW'(y_cur) + HW'(1);
    if (x_inc >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (y_inc >= h_eff) ? '0 : RW'(y_inc);
    end else begin
      col_cnt_d = CW'(x_inc);
      row_cnt_d = y_cur;
    end
    emit               = (x_cur >= CW'(LINES)) && (y_cur >= RW'(LINES));
    meta_s0.out_x      = gb2d_pkg::COORD_W'(x_cur - CW'(RADIUS));
    meta_s0.out_y      = gb2d_pkg::COORD_W'(y_cur - RW'(RADIUS));
    meta_s0.frame_done = (x_inc == w_eff) && (y_inc == h_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_accept) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  gb2d_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_line_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_addr_i    (x_cur),
    .in_slot_i    (y_cur[SLOT_W-1:0]),
    .in_pixel_i   (pixel_in_i),
    .in_emit_i    (emit),
    .in_meta_i    (meta_s0),
    .out_valid_o  (ls_valid),
    .out_ready_i  (win_in_ready),
    .out_column_o (ls_column),
    .out_emit_o   (ls_emit),
    .out_meta_o   (ls_meta)
  );

  gb2d_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (ls_valid),
    .in_ready_o   (win_in_ready),
    .in_column_i  (ls_column),
    .in_emit_i    (ls_emit),
    .in_meta_i    (ls_meta),
    .out_valid_o  (win_valid),
    .out_ready_i  (mac_in_ready),
    .out_window_o (win_data),
    .out_meta_o   (win_meta)
  );

  gb2d_mac #(
    .RADIUS      (RADIUS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (mac_in_ready),
    .in_window_i (win_data),
    .in_meta_i   (win_meta),
    .weights_i   (weights_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .blurred_o   (blurred_o),
    .out_meta_o  (out_meta)
  );

  assign out_x_o      = out_meta.out_x;
  assign out_y_o      = out_meta.out_y;
  assign frame_done_o = out_meta.frame_done;

  a_stall_needs_held_item: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ls_valid
  ) else $error("input stalled with the line store stage empty");

  a_frame_start_restarts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept && frame_start_i |=> (col_cnt_q <= CW'(1)) && (row_cnt_q <= RW'(1))
  ) else $error("frame start did not restart the counters");

  a_emit_reaches_window: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ls_valid && win_in_ready && ls_emit |=> win_valid
  ) else $error("interior item lost between line store and window");

endmodule

// ===== sv/gb2d_line_store.sv =====
module gb2d_line_store #(
  parameter int MAX_WIDTH = 4096,
  parameter int RADIUS    = 2,
  localparam int LINES    = 2 * RADIUS,
  localparam int DIAM     = 2 * RADIUS + 1,
  localparam int ADDR_W   = $clog2(MAX_WIDTH),
  localparam int SLOT_W   = $clog2(LINES)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [ADDR_W-1:0]                       in_addr_i,
  input  logic [SLOT_W-1:0]                       in_slot_i,
  input  logic [gb2d_pkg::PIX_W-1:0]              in_pixel_i,
  input  logic                                    in_emit_i,
  input  gb2d_pkg::item_meta_t                    in_meta_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [DIAM-1:0][gb2d_pkg::PIX_W-1:0]    out_column_o,
  output logic                                    out_emit_o,
  output gb2d_pkg::item_meta_t                    out_meta_o
);

  localparam int WORD_W = LINES * gb2d_pkg::PIX_W;

  logic [WORD_W-1:0]          line_mem [MAX_WIDTH];
  logic [WORD_W-1:0]          rdata_q;
  logic [WORD_W-1:0]          fwd_word_q;
  logic                       hit_q;
  logic                       valid_q;
  logic [ADDR_W-1:0]          addr_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [gb2d_pkg::PIX_W-1:0] pixel_q;
  logic                       emit_q;
  gb2d_pkg::item_meta_t       meta_q;

  logic              accept;
  logic              wr_en;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] wr_word;
  logic [SLOT_W-1:0] rd_slot [LINES];

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = valid_q && out_ready_i;
  assign cur_word   = hit_q ? fwd_word_q : rdata_q;

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      wr_word[k*gb2d_pkg::PIX_W +: gb2d_pkg::PIX_W] =
        (slot_q == SLOT_W'(k)) ? pixel_q : cur_word[k*gb2d_pkg::PIX_W +: gb2d_pkg::PIX_W];
    end
  end

  // Oldest row first: slot (current row + r) holds row y - LINES + r.
  always_comb begin
    for (int r = 0; r < LINES; r++) begin
      rd_slot[r]      = slot_q + SLOT_W'(r);
      out_column_o[r] = cur_word[rd_slot[r]*gb2d_pkg::PIX_W +: gb2d_pkg::PIX_W];
    end
    out_column_o[DIAM-1] = pixel_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[addr_q] <= wr_word;
    end
    if (accept) begin
      rdata_q <= line_mem[in_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Forward the word written in the same cycle as the read of that entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q      <= wr_en && (addr_q == in_addr_i);
      fwd_word_q <= wr_word;
      addr_q     <= in_addr_i;
      slot_q     <= in_slot_i;
      pixel_q    <= in_pixel_i;
      emit_q     <= in_emit_i;
      meta_q     <= in_meta_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_emit_o  = emit_q;
  assign out_meta_o  = meta_q;

endmodule

// ===== sv/gb2d_window.sv =====
module gb2d_window #(
  parameter int RADIUS = 2,
  localparam int DIAM  = 2 * RADIUS + 1
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  logic [DIAM-1:0][gb2d_pkg::PIX_W-1:0]               in_column_i,
  input  logic                                               in_emit_i,
  input  gb2d_pkg::item_meta_t                               in_meta_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [DIAM-1:0][DIAM-1:0][gb2d_pkg::PIX_W-1:0]     out_window_o,
  output gb2d_pkg::item_meta_t                               out_meta_o
);

  logic [DIAM-1:0][DIAM-1:0][gb2d_pkg::PIX_W-1:0] win_q;
  logic                                           valid_q;
  gb2d_pkg::item_meta_t                           meta_q;
  logic                                           accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        for (int r = 0; r < DIAM; r++) begin
          for (int c = 0; c < DIAM - 1; c++) begin
            win_q[r][c] <= win_q[r][c+1];
          end
          win_q[r][DIAM-1] <= in_column_i[r];
        end
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i && in_emit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q <= in_meta_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_window_o = win_q;
  assign out_meta_o   = meta_q;

endmodule

// ===== sv/gb2d_mac.sv =====
module gb2d_mac #(
  parameter int RADIUS      = 2,
  parameter int WEIGHT_BITS = 16,
  localparam int DIAM       = 2 * RADIUS + 1
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic [DIAM-1:0][DIAM-1:0][gb2d_pkg::PIX_W-1:0] in_window_i,
  input  gb2d_pkg::item_meta_t                           in_meta_i,
  input  gb2d_pkg::weight_set_t                          weights_i,
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output logic [gb2d_pkg::PIX_W-1:0]                     blurred_o,
  output gb2d_pkg::item_meta_t                           out_meta_o
);

  localparam int PROD_W = gb2d_pkg::PIX_W + gb2d_pkg::WGT_W;
  localparam int ROW_W  = PROD_W + $clog2(DIAM);
  localparam int ACC_W  = ROW_W + $clog2(DIAM);

  logic [DIAM-1:0][DIAM-1:0][PROD_W-1:0] prod_d;
  logic [DIAM-1:0][DIAM-1:0][PROD_W-1:0] prod_q;
  logic [DIAM-1:0][ROW_W-1:0]            row_d;
  logic [DIAM-1:0][ROW_W-1:0]            row_q;
  logic [ACC_W-1:0]                      acc;
  logic [ACC_W-1:0]                      acc_shr;
  logic [gb2d_pkg::PIX_W-1:0]            blurred_d;
  logic [gb2d_pkg::PIX_W-1:0]            blurred_q;
  gb2d_pkg::item_meta_t                  meta_a_q;
  gb2d_pkg::item_meta_t                  meta_b_q;
  gb2d_pkg::item_meta_t                  meta_c_q;
  logic                                  va_q;
  logic                                  vb_q;
  logic                                  vc_q;
  logic                                  en_a;
  logic                                  en_b;
  logic                                  en_c;

  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  for (genvar r = 0; r < DIAM; r++) begin : g_row
    for (genvar c = 0; c < DIAM; c++) begin : g_tap
      localparam int DY  = (r > RADIUS) ? r - RADIUS : RADIUS - r;
      localparam int DX  = (c > RADIUS) ? c - RADIUS : RADIUS - c;
      localparam int CLS = gb2d_pkg::tap_class(DY, DX);
      assign prod_d[r][c] = PROD_W'(in_window_i[r][c]) * PROD_W'(weights_i[CLS]);
    end
  end

  always_comb begin
    for (int r = 0; r < DIAM; r++) begin
      row_d[r] = '0;
      for (int c = 0; c < DIAM; c++) begin
        row_d[r] = row_d[r] + ROW_W'(prod_q[r][c]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int r = 0; r < DIAM; r++) begin
      acc = acc + ACC_W'(row_q[r]);
    end
    acc_shr = acc >> WEIGHT_BITS;
    if (|acc_shr[ACC_W-1:gb2d_pkg::PIX_W]) begin
      blurred_d = '1;
    end else begin
      blurred_d = acc_shr[gb2d_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= in_valid_i;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      prod_q   <= prod_d;
      meta_a_q <= in_meta_i;
    end
    if (en_b && va_q) begin
      row_q    <= row_d;
      meta_b_q <= meta_a_q;
    end
    if (en_c && vb_q) begin
      blurred_q <= blurred_d;
      meta_c_q  <= meta_b_q;
    end
  end

  assign out_valid_o = vc_q;
  assign blurred_o   = blurred_q;
  assign out_meta_o  = meta_c_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int RAD          = 2;
  localparam int SIDE         = 2 * RAD + 1;
  localparam int NLINES       = 2 * RAD;
  localparam int MAX_DIM      = 4096;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PHASES  = 8;
  localparam int RAND_ITEMS   = 90;

  localparam gb2d_pkg::weight_set_t RESET_WEIGHTS =
    {16'd194, 16'd872, 16'd1437, 16'd3908, 16'd6443, 16'd10624};
  localparam gb2d_pkg::weight_set_t FULL_WEIGHTS = '1;
  localparam gb2d_pkg::weight_set_t ZERO_WEIGHTS = '0;

  typedef struct packed {
    logic [gb2d_pkg::PIX_W-1:0]   blurred;
    logic [gb2d_pkg::COORD_W-1:0] col;
    logic [gb2d_pkg::COORD_W-1:0] row;
    logic                         last;
  } blur_px_t;

  typedef struct packed {
    logic [gb2d_pkg::PIX_W-1:0] pix;
    logic                       start;
    logic                       typed;
    blur_px_t                   blur;
  } dir_row_t;

  // one 5x5 frame at full-scale weights; its single result saturates
  localparam dir_row_t DIRECTED [25] = '{
    {8'hFF, 1'b1, 1'b0, 33'd0},
    {8'h00, 1'b0, 1'b0, 33'd0},
    {8'h55, 1'b0, 1'b0, 33'd0},
    {8'hAA, 1'b0, 1'b0, 33'd0},
    {8'h01, 1'b0, 1'b0, 33'd0},
    {8'h80, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'h7F, 1'b0, 1'b0, 33'd0},
    {8'hFE, 1'b0, 1'b0, 33'd0},
    {8'h02, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'h40, 1'b0, 1'b0, 33'd0},
    {8'h20, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'h10, 1'b0, 1'b0, 33'd0},
    {8'h04, 1'b0, 1'b0, 33'd0},
    {8'h08, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'hC3, 1'b0, 1'b0, 33'd0},
    {8'h3C, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b0, 33'd0},
    {8'hFF, 1'b0, 1'b1, {8'd255, 12'd2, 12'd2, 1'b1}}
  };

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [gb2d_pkg::IDX_W-1:0]    cfg_index_i   = '0;
  logic [gb2d_pkg::CFG_W-1:0]    cfg_data_i    = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [gb2d_pkg::PIX_W-1:0]    pixel_in_i    = '0;
  logic                          frame_start_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [gb2d_pkg::PIX_W-1:0]    blurred_o;
  logic [gb2d_pkg::COORD_W-1:0]  out_x_o;
  logic [gb2d_pkg::COORD_W-1:0]  out_y_o;
  logic                          frame_done_o;

  gaussian_blur_2d dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .blurred_o     (blurred_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .frame_done_o  (frame_done_o)
  );

  logic [gb2d_pkg::PIX_W-1:0] line_mem [NLINES*MAX_DIM];
  logic [gb2d_pkg::PIX_W-1:0] win [SIDE][SIDE];
  int unsigned                col_cnt;
  int unsigned                row_cnt;
  logic [gb2d_pkg::DIM_W-1:0] width_reg;
  logic [gb2d_pkg::DIM_W-1:0] height_reg;
  gb2d_pkg::weight_set_t      weights;

  blur_px_t pending_blur [$];
  logic     typed_valid = 1'b0;
  blur_px_t typed_px    = '0;

  int fail_count    = 0;
  int pixels_taken  = 0;
  int blur_checked  = 0;
  int phase_count   = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [gb2d_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [gb2d_pkg::WGT_W-1:0] tap_weight(int d2);
    case (d2)
      0:       return weights[gb2d_pkg::CLS_R2_0];
      1:       return weights[gb2d_pkg::CLS_R2_1];
      2:       return weights[gb2d_pkg::CLS_R2_2];
      4:       return weights[gb2d_pkg::CLS_R2_4];
      5:       return weights[gb2d_pkg::CLS_R2_5];
      8:       return weights[gb2d_pkg::CLS_R2_8];
      default: return '0;
    endcase
  endfunction

  function automatic void apply_reg(logic [gb2d_pkg::IDX_W-1:0] idx,
                                    logic [gb2d_pkg::CFG_W-1:0] data);
    case (gb2d_pkg::cfg_reg_e'(idx))
      gb2d_pkg::REG_IMAGE_WIDTH:  width_reg = data[gb2d_pkg::DIM_W-1:0];
      gb2d_pkg::REG_IMAGE_HEIGHT: height_reg = data[gb2d_pkg::DIM_W-1:0];
      gb2d_pkg::REG_WEIGHT_R2_0:  weights[gb2d_pkg::CLS_R2_0] = data;
      gb2d_pkg::REG_WEIGHT_R2_1:  weights[gb2d_pkg::CLS_R2_1] = data;
      gb2d_pkg::REG_WEIGHT_R2_2:  weights[gb2d_pkg::CLS_R2_2] = data;
      gb2d_pkg::REG_WEIGHT_R2_4:  weights[gb2d_pkg::CLS_R2_4] = data;
      gb2d_pkg::REG_WEIGHT_R2_5:  weights[gb2d_pkg::CLS_R2_5] = data;
      gb2d_pkg::REG_WEIGHT_R2_8:  weights[gb2d_pkg::CLS_R2_8] = data;
      default: ;
    endcase
  endfunction

  function automatic bit blur_step(logic [gb2d_pkg::PIX_W-1:0] pix, logic start,
                                   output blur_px_t res);
    int unsigned                w, h, x, y, ln;
    logic [gb2d_pkg::PIX_W-1:0] column [SIDE];
    logic [31:0]                acc;
    bit                         hit;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    hit = 1'b0;
    res = '0;
    if (start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    for (int d = 1; d <= NLINES; d++) begin
      ln = (y + NLINES * MAX_DIM - d) % NLINES;
      column[SIDE-1-d] = line_mem[ln*MAX_DIM + x];
    end
    column[SIDE-1] = pix;
    line_mem[(y % NLINES)*MAX_DIM + x] = pix;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE - 1; c++) win[r][c] = win[r][c+1];
      win[r][SIDE-1] = column[r];
    end
    if (x >= NLINES && y >= NLINES) begin
      acc = '0;
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE; c++) begin
          acc = acc + tap_weight((r - RAD) * (r - RAD) + (c - RAD) * (c - RAD)) * win[r][c];
        end
      end
      acc = acc >> gb2d_pkg::WGT_W;
      res.blurred = (acc > 255) ? 8'd255 : acc[gb2d_pkg::PIX_W-1:0];
      res.col     = gb2d_pkg::COORD_W'(x - RAD);
      res.row     = gb2d_pkg::COORD_W'(y - RAD);
      res.last    = (x == w - 1) && (y == h - 1);
      hit = 1'b1;
    end
    col_cnt = x + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = y + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    return hit;
  endfunction

  always @(posedge clk_i) begin
    blur_px_t predicted;
    blur_px_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        pixels_taken++;
        if (blur_step(pixel_in_i, frame_start_i, predicted)) begin
          pending_blur.push_back(typed_valid ? typed_px : predicted);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_blur.size() == 0) begin
          $error("blurred item at (%0d,%0d) with none pending", out_x_o, out_y_o);
          fail_count++;
        end else begin
          want = pending_blur.pop_front();
          blur_checked++;
          if (blurred_o !== want.blurred) begin
            $error("blurred: expected %0d, got %0d", want.blurred, blurred_o);
            fail_count++;
          end
          if (out_x_o !== want.col) begin
            $error("out_x: expected %0d, got %0d", want.col, out_x_o);
            fail_count++;
          end
          if (out_y_o !== want.row) begin
            $error("out_y: expected %0d, got %0d", want.row, out_y_o);
            fail_count++;
          end
          if (frame_done_o !== want.last) begin
            $error("frame_done: expected %0b, got %0b", want.last, frame_done_o);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic send_pixel(logic [gb2d_pkg::PIX_W-1:0] pix, logic start);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_in_i    <= pix;
    frame_start_i <= start;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
  endtask

  task automatic write_reg(gb2d_pkg::cfg_reg_e idx, logic [gb2d_pkg::CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [gb2d_pkg::CFG_W-1:0] w, logic [gb2d_pkg::CFG_W-1:0] h,
                             gb2d_pkg::weight_set_t ws);
    write_reg(gb2d_pkg::REG_IMAGE_WIDTH, w);
    write_reg(gb2d_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(gb2d_pkg::REG_WEIGHT_R2_0, ws[gb2d_pkg::CLS_R2_0]);
    write_reg(gb2d_pkg::REG_WEIGHT_R2_1, ws[gb2d_pkg::CLS_R2_1]);
    write_reg(gb2d_pkg::REG_WEIGHT_R2_2, ws[gb2d_pkg::CLS_R2_2]);
    write_reg(gb2d_pkg::REG_WEIGHT_R2_4, ws[gb2d_pkg::CLS_R2_4]);
    write_reg(gb2d_pkg::REG_WEIGHT_R2_5, ws[gb2d_pkg::CLS_R2_5]);
    write_reg(gb2d_pkg::REG_WEIGHT_R2_8, ws[gb2d_pkg::CLS_R2_8]);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid, wait out every pending result plus the pipeline tail
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic gb2d_pkg::weight_set_t random_weights(bit heavy);
    gb2d_pkg::weight_set_t ws;
    for (int i = 0; i < gb2d_pkg::W_CLASSES; i++) begin
      ws[i] = heavy ? gb2d_pkg::WGT_W'($urandom_range(65535))
                    : gb2d_pkg::WGT_W'($urandom_range(2600));
    end
    return ws;
  endfunction

  // whole frames with random content; some unmarked, a few cut short
  task automatic run_phase(logic [gb2d_pkg::CFG_W-1:0] w_data,
                           logic [gb2d_pkg::CFG_W-1:0] h_data,
                           gb2d_pkg::weight_set_t ws, int snd, int rcv, int n_items);
    int unsigned frame_len, pos;
    logic        start;
    load_config(w_data, h_data, ws);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    frame_len = clamp_dim(w_data[gb2d_pkg::DIM_W-1:0]) * clamp_dim(h_data[gb2d_pkg::DIM_W-1:0]);
    pos = 0;
    for (int n = 0; n < n_items; n++) begin
      start = (n == 0) || (pos == 0 && $urandom_range(9) != 0) || ($urandom_range(199) == 0);
      send_pixel(gb2d_pkg::PIX_W'($urandom_range(255)), start);
      pos = start ? 1 : pos + 1;
      if (pos >= frame_len) pos = 0;
    end
    settle();
    phase_count++;
  endtask

  initial begin
    width_reg  = 640;
    height_reg = 480;
    weights    = RESET_WEIGHTS;
    col_cnt    = 0;
    row_cnt    = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    load_config(16'd5, 16'd5, FULL_WEIGHTS);
    foreach (DIRECTED[i]) begin
      typed_valid = DIRECTED[i].typed;
      typed_px    = DIRECTED[i].blur;
      send_pixel(DIRECTED[i].pix, DIRECTED[i].start);
    end
    typed_valid = 1'b0;
    settle();
    phase_count++;

    run_phase(16'd0, 16'd5, RESET_WEIGHTS, 35, 35, 30);
    run_phase(16'd4, 16'd9, random_weights(1'b0), 67, 0, 40);
    run_phase(16'd9, 16'd0, random_weights(1'b0), 0, 67, 20);
    run_phase(16'd7, 16'd4, random_weights(1'b0), 0, 0, 30);
    run_phase(16'd6, 16'd6, ZERO_WEIGHTS, 35, 35, 40);
    run_phase(16'hFFFF, 16'd5, RESET_WEIGHTS, 0, 0, 50);
    run_phase(16'd5, 16'd4096, random_weights(1'b0), 0, 0, 50);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: run_phase(16'($urandom_range(5, 12)), 16'($urandom_range(5, 9)),
                     random_weights(p == 4), 0, 0, RAND_ITEMS);
        1: run_phase(16'($urandom_range(5, 12)), 16'($urandom_range(5, 9)),
                     random_weights(p == 5), 67, 0, RAND_ITEMS);
        2: run_phase(16'($urandom_range(5, 12)), 16'($urandom_range(5, 9)),
                     random_weights(p == 2), 0, 67, RAND_ITEMS);
        default: run_phase(16'($urandom_range(5, 12)), 16'($urandom_range(5, 9)),
                           random_weights(p == 7), 35, 35, RAND_ITEMS);
      endcase
    end

    $display("Streamed %0d pixels, checked %0d blurred items over %0d frame setups",
             pixels_taken, blur_checked, phase_count);
    $display("Sizes 1 to 4096 per side; weights zero, full scale, reset and random");
    if (fail_count == 0 && pending_blur.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d blurred items pending", pending_blur.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gb2d_pkg.sv
sv/gb2d_line_store.sv
sv/gb2d_window.sv
sv/gb2d_mac.sv
sv/gaussian_blur_2d.sv
tb/tb_top.sv
